// ===== src/mdwm_pkg.sv =====
// Shared types, constants and the arctangent table for the mecanum wheel mixer.
`timescale 1ns / 1ps

package mdwm_pkg;

    // Number formats
    localparam int ANGLE_BITS = 16;
    localparam int FRAC_BITS  = 15;
    localparam int GUARD      = 8;
    localparam int ITERS      = 16;
    localparam int CMD_W      = 16;
    localparam int Z_W        = 32;
    localparam int XY_W       = CMD_W + GUARD + 3;
    localparam int GAIN_W     = 32;
    localparam int PROD_W     = XY_W + GAIN_W - 1;
    localparam int MAG_W      = XY_W - 1;
    localparam int Q_W        = FRAC_BITS + GUARD + 1;
    localparam int NUM_W      = MAG_W + Q_W;
    localparam int MAXV_W     = 15;
    localparam int SUM_W      = Q_W + MAXV_W + 1;
    localparam int RES_W      = 17;
    localparam int OUT_W      = 16;
    localparam int WHEELS     = 4;

    // CORDIC gain in Q30
    localparam logic signed [GAIN_W-1:0] GAIN_Q30 = 32'sd652032874;
    localparam logic [MAG_W-1:0] ONE = MAG_W'(1) << (FRAC_BITS + GUARD);

    // Configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_VELOCITY_MODE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_VELOCITY  = 8'd1;
    localparam logic [MAXV_W-1:0]    MAXV_RESET        = 15'd4096;

    typedef logic signed [XY_W-1:0] wheel_t;

    // Normalized wheel magnitudes with their signs
    typedef struct packed {
        logic                         scaled;
        logic [WHEELS-1:0]            neg;
        logic [WHEELS-1:0][Q_W-1:0]   mag;
    } norm_t;

    // Arctangent of 2^-i as a turn fraction in 32 bits
    function automatic logic signed [Z_W-1:0] atan_at(input logic [3:0] i);
        logic signed [Z_W-1:0] v;
        begin
            case (i)
                4'd0:    v = 32'sh20000000;
                4'd1:    v = 32'sh12E4051E;
                4'd2:    v = 32'sh09FB385B;
                4'd3:    v = 32'sh051111D4;
                4'd4:    v = 32'sh028B0D43;
                4'd5:    v = 32'sh0145D7E1;
                4'd6:    v = 32'sh00A2F61E;
                4'd7:    v = 32'sh00517C55;
                4'd8:    v = 32'sh0028BE53;
                4'd9:    v = 32'sh00145F2F;
                4'd10:   v = 32'sh000A2F98;
                4'd11:   v = 32'sh000517CC;
                4'd12:   v = 32'sh00028BE6;
                4'd13:   v = 32'sh000145F3;
                4'd14:   v = 32'sh0000A2FA;
                default: v = 32'sh0000517D;
            endcase
            return v;
        end
    endfunction

endpackage

// ===== src/mecanum_drive_wheel_mixer.sv =====
// Top level of the field-oriented mecanum wheel mixer.
// Throughput: one word per cycle unless the output stalls; the 16-step CORDIC
// and the 24-step divider are fully pipelined, so every stage advances together.
// The whole pipeline holds while an output word waits for m_axis_tready.
// Reset empties the pipeline and sets velocity_mode to 1, max_velocity to 4096.
`timescale 1ns / 1ps

module mecanum_drive_wheel_mixer
    import mdwm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // forward_cmd[15:0], strafe_cmd[31:16], turn_cmd[47:32], heading[63:48]
    input  logic [63:0]           s_axis_tdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // front_left[15:0], front_right[31:16], rear_left[47:32], rear_right[63:48]
    output logic [63:0]           m_axis_tdata,
    // was_scaled[0]
    output logic [0:0]            m_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic              en;
    logic              mode_reg;
    logic [MAXV_W-1:0] maxv_reg;
    logic              c_valid;
    wheel_t            wheel [WHEELS];
    logic              n_valid;
    norm_t             norm;
    logic              scaled_out;

    // Advance the pipeline unless the output word is held
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;
    assign cfg_ready     = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b1;
            maxv_reg <= MAXV_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_VELOCITY_MODE: mode_reg <= cfg_data[0];
                REG_MAX_VELOCITY:  maxv_reg <= cfg_data[MAXV_W-1:0];
                default:           ;
            endcase
        end
    end

    mdwm_cordic u_cordic (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (s_axis_tvalid),
        .forward_cmd (signed'(s_axis_tdata[15:0])),
        .strafe_cmd  (signed'(s_axis_tdata[31:16])),
        .turn_cmd    (signed'(s_axis_tdata[47:32])),
        .heading     (s_axis_tdata[63:48]),
        .out_valid   (c_valid),
        .wheel       (wheel)
    );

    mdwm_norm u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (c_valid),
        .wheel     (wheel),
        .out_valid (n_valid),
        .norm      (norm)
    );

    mdwm_out u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .in_valid      (n_valid),
        .norm          (norm),
        .velocity_mode (mode_reg),
        .max_velocity  (maxv_reg),
        .out_valid     (m_axis_tvalid),
        .speeds        (m_axis_tdata),
        .was_scaled    (scaled_out)
    );

    assign m_axis_tuser[0] = scaled_out;

endmodule

// ===== src/mdwm_cordic.sv =====
// Heading rotation by a pipelined CORDIC, gain correction and wheel mixing.
`timescale 1ns / 1ps

module mdwm_cordic
    import mdwm_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic signed [CMD_W-1:0] forward_cmd,
    input  logic signed [CMD_W-1:0] strafe_cmd,
    input  logic signed [CMD_W-1:0] turn_cmd,
    input  logic [ANGLE_BITS-1:0]   heading,
    output logic                    out_valid,
    output wheel_t                  wheel [WHEELS]
);

    logic signed [XY_W-1:0]   x_reg [0:ITERS];
    logic signed [XY_W-1:0]   y_reg [0:ITERS];
    logic signed [Z_W-1:0]    z_reg [0:ITERS];
    logic signed [CMD_W-1:0]  r_reg [0:ITERS];
    logic [ITERS:0]           v_reg;

    logic signed [XY_W-1:0]   x_in;
    logic signed [XY_W-1:0]   y_in;
    logic [Z_W-1:0]           a_in;
    logic                     flip;

    logic signed [PROD_W-1:0] px_next, py_next, px_reg, py_reg;
    logic signed [CMD_W-1:0]  rm_reg;
    logic                     vm_reg;

    logic signed [PROD_W-1:0] px_rnd, py_rnd;
    logic signed [XY_W-1:0]   rx, ry, rr;
    wheel_t                   w_reg [WHEELS];
    logic                     vw_reg;

    // Widen the commands and fold the angle into the right half plane
    always_comb
    begin
        x_in = {{(XY_W-CMD_W-GUARD){strafe_cmd[CMD_W-1]}}, strafe_cmd, GUARD'(0)};
        y_in = {{(XY_W-CMD_W-GUARD){forward_cmd[CMD_W-1]}}, forward_cmd, GUARD'(0)};
        a_in = {heading, (Z_W-ANGLE_BITS)'(0)};
        flip = a_in[Z_W-1] ^ a_in[Z_W-2];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= flip ? -x_in : x_in;
            y_reg[0] <= flip ? -y_in : y_in;
            z_reg[0] <= signed'(flip ? {~a_in[Z_W-1], a_in[Z_W-2:0]} : a_in);
            r_reg[0] <= turn_cmd;
        end
    end

    // One rotation step per stage
    for (genvar i = 0; i < ITERS; i++)
    begin : g_iter
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!z_reg[i][Z_W-1])
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - atan_at(4'(i));
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + atan_at(4'(i));
                end
                r_reg[i+1] <= r_reg[i];
            end
        end
    end

    // Gain correction products
    assign px_next = PROD_W'(x_reg[ITERS]) * PROD_W'(GAIN_Q30);
    assign py_next = PROD_W'(y_reg[ITERS]) * PROD_W'(GAIN_Q30);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg <= px_next;
            py_reg <= py_next;
            rm_reg <= r_reg[ITERS];
        end
    end

    // Round the products and form the four wheel sums
    always_comb
    begin
        px_rnd = (px_reg + (PROD_W'(1) <<< 29)) >>> 30;
        py_rnd = (py_reg + (PROD_W'(1) <<< 29)) >>> 30;
        rx     = signed'(px_rnd[XY_W-1:0]);
        ry     = signed'(py_rnd[XY_W-1:0]);
        rr     = {{(XY_W-CMD_W-GUARD){rm_reg[CMD_W-1]}}, rm_reg, GUARD'(0)};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w_reg[0] <= ry + rx + rr;
            w_reg[1] <= ry - rx - rr;
            w_reg[2] <= ry - rx + rr;
            w_reg[3] <= ry + rx - rr;
        end
    end

    // Advance valid bits with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg  <= '0;
            vm_reg <= 1'b0;
            vw_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg  <= {v_reg[ITERS-1:0], in_valid};
            vm_reg <= v_reg[ITERS];
            vw_reg <= vm_reg;
        end
    end

    assign out_valid = vw_reg;
    assign wheel     = w_reg;

endmodule

// ===== src/mdwm_norm.sv =====
// Largest magnitude search and pipelined division that normalizes the wheels.
`timescale 1ns / 1ps

module mdwm_norm
    import mdwm_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   en,
    input  logic   in_valid,
    input  wheel_t wheel [WHEELS],
    output logic   out_valid,
    output norm_t  norm
);

    logic [MAG_W-1:0]  ma_reg [WHEELS];
    logic [WHEELS-1:0] na_reg;
    logic              va_reg;

    logic [MAG_W-1:0]  mb_reg [WHEELS];
    logic [WHEELS-1:0] nb_reg;
    logic [MAG_W-1:0]  mx_reg;
    logic              vb_reg;
    logic [MAG_W-1:0]  max01, max23, max_all;

    logic [MAG_W-1:0]  rem_reg  [0:Q_W][WHEELS];
    logic [Q_W-1:0]    word_reg [0:Q_W][WHEELS];
    logic [Q_W-1:0]    keep_reg [0:Q_W][WHEELS];
    logic [WHEELS-1:0] neg_reg  [0:Q_W];
    logic [MAG_W-1:0]  div_reg  [0:Q_W];
    logic [Q_W:0]      sc_reg;
    logic [Q_W:0]      v_reg;
    logic [NUM_W-1:0]  num [WHEELS];

    // Take magnitudes and signs
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < WHEELS; k++)
            begin
                na_reg[k] <= wheel[k][XY_W-1];
                ma_reg[k] <= wheel[k][XY_W-1] ? MAG_W'(-wheel[k]) : MAG_W'(wheel[k]);
            end
        end
    end

    // Find the largest magnitude
    always_comb
    begin
        max01   = (ma_reg[0] > ma_reg[1]) ? ma_reg[0] : ma_reg[1];
        max23   = (ma_reg[2] > ma_reg[3]) ? ma_reg[2] : ma_reg[3];
        max_all = (max01 > max23) ? max01 : max23;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mb_reg <= ma_reg;
            nb_reg <= na_reg;
            mx_reg <= max_all;
        end
    end

    // Load the dividend: magnitude times one plus half the divisor
    always_comb
    begin
        for (int k = 0; k < WHEELS; k++)
        begin
            num[k] = NUM_W'({mb_reg[k], (Q_W-1)'(0)}) + NUM_W'(mx_reg >> 1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < WHEELS; k++)
            begin
                rem_reg[0][k]  <= num[k][NUM_W-1:Q_W];
                word_reg[0][k] <= num[k][Q_W-1:0];
                keep_reg[0][k] <= mb_reg[k][Q_W-1:0];
            end
            neg_reg[0] <= nb_reg;
            div_reg[0] <= mx_reg;
        end
    end

    // One quotient bit per stage in every lane
    for (genvar s = 0; s < Q_W; s++)
    begin : g_div
        for (genvar k = 0; k < WHEELS; k++)
        begin : g_lane
            logic [MAG_W:0] trial;
            logic           ge;

            always_comb
            begin
                trial = {rem_reg[s][k], word_reg[s][k][Q_W-1]};
                ge    = trial >= {1'b0, div_reg[s]};
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[s+1][k]  <= ge ? MAG_W'(trial - {1'b0, div_reg[s]})
                                           : MAG_W'(trial);
                    word_reg[s+1][k] <= {word_reg[s][k][Q_W-2:0], ge};
                    keep_reg[s+1][k] <= keep_reg[s][k];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                neg_reg[s+1] <= neg_reg[s];
                div_reg[s+1] <= div_reg[s];
            end
        end
    end

    // Hold the divide flag beside the lanes
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sc_reg <= {sc_reg[Q_W-1:0], (mx_reg > ONE)};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            v_reg  <= '0;
        end
        else if (en)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            v_reg  <= {v_reg[Q_W-1:0], vb_reg};
        end
    end

    // Pick the quotient only when the wheels were divided
    always_comb
    begin
        norm.scaled = sc_reg[Q_W];
        norm.neg    = neg_reg[Q_W];
        for (int k = 0; k < WHEELS; k++)
        begin
            norm.mag[k] = sc_reg[Q_W] ? word_reg[Q_W][k] : keep_reg[Q_W][k];
        end
    end

    assign out_valid = v_reg[Q_W];

endmodule

// ===== src/mdwm_out.sv =====
// Output scaling by mode, rounding, saturation and the output word register.
`timescale 1ns / 1ps

module mdwm_out
    import mdwm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  norm_t             norm,
    input  logic              velocity_mode,
    input  logic [MAXV_W-1:0] max_velocity,
    output logic              out_valid,
    output logic [4*OUT_W-1:0] speeds,
    output logic              was_scaled
);

    logic [SUM_W-1:0]  sum_reg [WHEELS];
    logic [WHEELS-1:0] neg_reg;
    logic              sc_reg;
    logic              mode_reg;
    logic              vp_reg;

    logic [SUM_W-1:0]  shifted [WHEELS];
    logic [RES_W-1:0]  res [WHEELS];
    logic [OUT_W-1:0]  sat [WHEELS];
    logic [4*OUT_W-1:0] spd_reg;
    logic              ws_reg;
    logic              vo_reg;

    // Scale by max velocity or drop the guard bits, with rounding
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < WHEELS; k++)
            begin
                if (velocity_mode)
                    sum_reg[k] <= SUM_W'(norm.mag[k]) * SUM_W'(max_velocity)
                                  + (SUM_W'(1) << (FRAC_BITS + GUARD - 1));
                else
                    sum_reg[k] <= SUM_W'(norm.mag[k]) + (SUM_W'(1) << (GUARD - 1));
            end
            neg_reg  <= norm.neg;
            sc_reg   <= norm.scaled;
            mode_reg <= velocity_mode;
        end
    end

    // Restore the sign and saturate
    always_comb
    begin
        for (int k = 0; k < WHEELS; k++)
        begin
            shifted[k] = mode_reg ? (sum_reg[k] >> (FRAC_BITS + GUARD))
                                  : (sum_reg[k] >> GUARD);
            res[k]     = shifted[k][RES_W-1:0];
            if (!neg_reg[k])
                sat[k] = (res[k] > RES_W'(32767)) ? 16'h7FFF : res[k][OUT_W-1:0];
            else
                sat[k] = (res[k] > RES_W'(32768)) ? 16'h8000 : OUT_W'(-res[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < WHEELS; k++)
            begin
                spd_reg[k*OUT_W +: OUT_W] <= sat[k];
            end
            ws_reg <= sc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vp_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else if (en)
        begin
            vp_reg <= in_valid;
            vo_reg <= vp_reg;
        end
    end

    assign out_valid  = vo_reg;
    assign speeds     = spd_reg;
    assign was_scaled = ws_reg;

endmodule

// ===== src/mdwm_checker.sv =====
// Port-level checks for the mecanum wheel mixer, bound to the top level.
`timescale 1ns / 1ps

module mdwm_checker
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tready,
    input logic [63:0]           m_axis_tdata,
    input logic [0:0]            m_axis_tuser,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic                  cfg_ready
);

    // Input side opens whenever the output word can move
    a_ready_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not track output stall");

    // Configuration writes are never refused
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port not ready");

    // A stalled output word keeps its valid
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output word dropped while stalled");

    // A stalled output word keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output word changed while stalled");

endmodule

bind mecanum_drive_wheel_mixer mdwm_checker u_mdwm_checker (.*);

// ===== verif/tb_mecanum_drive_wheel_mixer.sv =====
// Self-checking testbench for the field-oriented mecanum wheel mixer.
`timescale 1ns / 1ps

module tb_mecanum_drive_wheel_mixer;
    import mdwm_pkg::*;

    localparam int LATENCY     = 48;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic        scaled;
        logic [15:0] rr;
        logic [15:0] rl;
        logic [15:0] fr;
        logic [15:0] fl;
    } wheels_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic [63:0]           s_axis_tdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [63:0]           m_axis_tdata;
    logic [0:0]            m_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Model copy of the configuration registers
    logic                  mdl_velocity_mode;
    logic [14:0]           mdl_max_velocity;

    wheels_t               expected_wheels[$];
    int                    fail_count = 0;
    int                    cycle_count = 0;
    bit                    idle_enable = 1'b1;

    mecanum_drive_wheel_mixer i_dut (.*);

    // Clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("mecanum_drive_wheel_mixer regression: fail");
            $finish;
        end
    end

    function automatic longint floor_shift(longint v, int s);
        if (v >= 0)
            return v >>> s;
        return -(((-v) - 1) >>> s) - 1;
    endfunction

    function automatic longint round_scale(longint num, longint mul, longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = (mag * mul + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic logic [15:0] saturate16(longint v);
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[15:0];
    endfunction

    function automatic longint atan_step(int i);
        case (i)
            0:  return 64'h20000000;
            1:  return 64'h12E4051E;
            2:  return 64'h09FB385B;
            3:  return 64'h051111D4;
            4:  return 64'h028B0D43;
            5:  return 64'h0145D7E1;
            6:  return 64'h00A2F61E;
            7:  return 64'h00517C55;
            8:  return 64'h0028BE53;
            9:  return 64'h00145F2F;
            10: return 64'h000A2F98;
            11: return 64'h000517CC;
            12: return 64'h00028BE6;
            13: return 64'h000145F3;
            14: return 64'h0000A2FA;
            default: return 64'h0000517D;
        endcase
    endfunction

    // Rotate the command by the heading, mix, normalize and scale
    function automatic wheels_t mix_wheels(logic [63:0] cmd);
        longint full;
        longint y;
        longint x;
        longint r;
        longint z;
        longint dx;
        longint dy;
        longint rx;
        longint ry;
        longint m;
        longint t;
        longint v;
        longint w[4];
        logic [31:0] a;
        logic [15:0] o[4];
        wheels_t res;
        full = longint'(1) << (FRAC_BITS + GUARD);
        y = longint'($signed(cmd[15:0])) * 256;
        x = longint'($signed(cmd[31:16])) * 256;
        r = longint'($signed(cmd[47:32])) * 256;
        a = {cmd[63:48], 16'h0};
        if (a >= 32'h40000000 && a < 32'hC0000000)
        begin
            x = -x;
            y = -y;
            a = a - 32'h80000000;
        end
        z = longint'($signed(a));
        for (int i = 0; i < ITERS; i++)
        begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= atan_step(i);
            end
            else
            begin
                x += dx;
                y -= dy;
                z += atan_step(i);
            end
        end
        rx = floor_shift(x * 652032874 + (longint'(1) << 29), 30);
        ry = floor_shift(y * 652032874 + (longint'(1) << 29), 30);
        w[0] = ry + rx + r;
        w[1] = ry - rx - r;
        w[2] = ry - rx + r;
        w[3] = ry + rx - r;
        m = 0;
        for (int i = 0; i < 4; i++)
        begin
            t = (w[i] < 0) ? -w[i] : w[i];
            if (t > m)
                m = t;
        end
        res.scaled = (m > full);
        for (int i = 0; i < 4; i++)
        begin
            if (res.scaled)
                w[i] = round_scale(w[i], full, m);
            if (mdl_velocity_mode)
                v = round_scale(w[i], longint'(mdl_max_velocity), full);
            else
                v = round_scale(w[i], 1, 256);
            o[i] = saturate16(v);
        end
        res.fl = o[0];
        res.fr = o[1];
        res.rl = o[2];
        res.rr = o[3];
        return res;
    endfunction

    // Drop valid for a random burst of idle cycles
    task automatic idle_gap();
        if (idle_enable && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
    endtask

    // Send one command word and queue its prediction
    task automatic send_command(logic [15:0] fwd, logic [15:0] strafe,
                                logic [15:0] turn, logic [15:0] heading);
        logic [63:0] word;
        word = {heading, turn, strafe, fwd};
        idle_gap();
        s_axis_tdata  <= word;
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        expected_wheels.push_back(mix_wheels(word));
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_wheels.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == REG_VELOCITY_MODE)
            mdl_velocity_mode = value[0];
        else if (idx == REG_MAX_VELOCITY)
            mdl_max_velocity = value[14:0];
        @(posedge clk);
    endtask

    // Receiver stalls
    always @(posedge clk)
    begin
        if (idle_enable && $urandom_range(0, 15) == 0)
            m_axis_tready <= 1'b0;
        else if (!idle_enable || $urandom_range(0, 2) == 0)
            m_axis_tready <= 1'b1;
    end

    // Compare each output word with the oldest prediction
    always @(posedge clk)
    begin
        wheels_t exp_w;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_wheels.size() == 0)
            begin
                $error("unexpected output word %h", m_axis_tdata);
                fail_count++;
            end
            else
            begin
                exp_w = expected_wheels.pop_front();
                if (m_axis_tdata[15:0] !== exp_w.fl)
                begin
                    $error("front_left_speed exp %h got %h", exp_w.fl, m_axis_tdata[15:0]);
                    fail_count++;
                end
                if (m_axis_tdata[31:16] !== exp_w.fr)
                begin
                    $error("front_right_speed exp %h got %h", exp_w.fr, m_axis_tdata[31:16]);
                    fail_count++;
                end
                if (m_axis_tdata[47:32] !== exp_w.rl)
                begin
                    $error("rear_left_speed exp %h got %h", exp_w.rl, m_axis_tdata[47:32]);
                    fail_count++;
                end
                if (m_axis_tdata[63:48] !== exp_w.rr)
                begin
                    $error("rear_right_speed exp %h got %h", exp_w.rr, m_axis_tdata[63:48]);
                    fail_count++;
                end
                if (m_axis_tuser[0] !== exp_w.scaled)
                begin
                    $error("was_scaled exp %b got %b", exp_w.scaled, m_axis_tuser[0]);
                    fail_count++;
                end
            end
        end
    end

    task automatic test_directed();
        logic [15:0] ext[5];
        ext = '{16'h8000, 16'h7FFF, 16'h0000, 16'h0001, 16'hFFFF};
        // full-speed forward at heading zero saturates in percent mode
        send_command(16'h7FFF, 16'h0000, 16'h0000, 16'h0000);
        send_command(16'h8000, 16'h8000, 16'h8000, 16'h0000);
        send_command(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h4000);
        send_command(16'h8000, 16'h7FFF, 16'h8000, 16'h8000);
        send_command(16'h7FFF, 16'h8000, 16'h7FFF, 16'hC000);
        send_command(16'h4000, 16'h2000, 16'h0000, 16'hFFFF);
        send_command(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        for (int i = 0; i < 5; i++)
            send_command(ext[i], ext[(i + 1) % 5], ext[(i + 2) % 5],
                         16'h3FFF + 16'(i * 16'h4000));
        // quadrant boundaries
        send_command(16'h2000, 16'h1000, 16'h0800, 16'h3FFF);
        send_command(16'h2000, 16'h1000, 16'h0800, 16'h4000);
        send_command(16'h2000, 16'h1000, 16'h0800, 16'hBFFF);
        send_command(16'h2000, 16'h1000, 16'h0800, 16'hC000);
        send_command(16'h0000, 16'h0000, 16'h8000, 16'h1234);
    endtask

    task automatic test_random(int count);
        logic [15:0] f[3];
        for (int n = 0; n < count; n++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                case ($urandom_range(0, 3))
                    0:       f[k] = 16'($urandom_range(0, 65535));
                    1:       f[k] = 16'($signed(16'($urandom_range(0, 16383))) - 8192);
                    2:       f[k] = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
                    default: f[k] = 16'($urandom_range(0, 4095));
                endcase
            end
            send_command(f[0], f[1], f[2], 16'($urandom_range(0, 65535)));
        end
    endtask

    task automatic test_config_sweep();
        logic [15:0] maxv[4];
        maxv = '{16'h0000, 16'hFFFF, 16'h0001, 16'h1234};
        // percent mode, written with a wide value whose low bit is zero
        drain();
        write_register(REG_VELOCITY_MODE, 16'hFFFE);
        test_directed();
        test_random(300);
        // velocity mode over several maximum velocities, extremes included
        for (int i = 0; i < 4; i++)
        begin
            drain();
            write_register(REG_VELOCITY_MODE, 16'h0001);
            write_register(REG_MAX_VELOCITY, maxv[i]);
            // writes to unknown indexes are ignored
            write_register(8'd2, 16'h0000);
            write_register(8'hFF, 16'hFFFF);
            test_random(200);
        end
        drain();
        write_register(REG_VELOCITY_MODE, 16'h0000);
        write_register(REG_MAX_VELOCITY, 16'h7FFF);
        test_random(200);
    endtask

    initial
    begin
        mdl_velocity_mode = 1'b1;
        mdl_max_velocity  = MAXV_RESET;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // reset settings: velocity mode at 4096
        test_directed();
        test_random(200);
        test_config_sweep();
        // final stretch with no idling
        idle_enable = 1'b0;
        test_random(200);
        drain();
        if (fail_count == 0)
            $display("mecanum_drive_wheel_mixer regression: pass");
        else
            $display("mecanum_drive_wheel_mixer regression: fail");
        $finish;
    end

endmodule
